### hw/rtl/cau_pkg.sv
package cau_pkg;

   // Fixed-point format of every operand and result part
   localparam int WORD_BITS = 16;
   localparam int FRAC_BITS = 8;
   localparam int MAG_BITS  = 2 * WORD_BITS;
   localparam int SQ_BITS   = WORD_BITS + 2;

   // Opcodes
   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_MAG = 3'd4;

   // Status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIVZ = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   typedef struct packed {
      logic [2:0]                  opcode;
      logic signed [WORD_BITS-1:0] a_re;
      logic signed [WORD_BITS-1:0] a_im;
      logic signed [WORD_BITS-1:0] b_re;
      logic signed [WORD_BITS-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] res_re;
      logic signed [WORD_BITS-1:0] res_im;
      logic [1:0]                  status;
   } rsp_type;

   // Data carried down the pipeline, one copy in the combine stage and each step stage
   typedef struct packed {
      logic                 valid;
      logic [2:0]           op;
      logic                 divz;
      logic                 re_neg;
      logic [MAG_BITS-1:0]  re_mag;
      logic                 im_neg;
      logic [MAG_BITS-1:0]  im_mag;
      logic                 re_ovf;
      logic                 im_ovf;
      logic [MAG_BITS-1:0]  den;
      logic [MAG_BITS-1:0]  re_rem;
      logic [MAG_BITS-1:0]  im_rem;
      logic [WORD_BITS-1:0] re_lo;
      logic [WORD_BITS-1:0] im_lo;
      logic [WORD_BITS-1:0] re_q;
      logic [WORD_BITS-1:0] im_q;
      logic [MAG_BITS-1:0]  sq_s;
      logic [SQ_BITS-1:0]   sq_rem;
      logic [WORD_BITS-1:0] sq_q;
   } pipe_type;

   // Magnitude of a signed value one bit wider than the magnitude
   function automatic logic [MAG_BITS-1:0] abs_mag(input logic [MAG_BITS:0] x);
      logic [MAG_BITS:0] n;
      n = x[MAG_BITS] ? (~x + 1'b1) : x;
      return n[MAG_BITS-1:0];
   endfunction

endpackage

### hw/rtl/cau_front.sv
module cau_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  cau_pkg::req_type  req_data,
   output cau_pkg::pipe_type pipe_out
);

   localparam int W  = cau_pkg::WORD_BITS;
   localparam int F  = cau_pkg::FRAC_BITS;
   localparam int MW = cau_pkg::MAG_BITS;

   // Stage 1: capture request
   logic             s1_valid_ff;
   cau_pkg::req_type s1_ff;

   always_ff @(posedge clock) begin
      s1_ff <= req_data;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
      end
   end

   // Stage 2: products and plain sums
   logic signed [MW-1:0] p_rr_in, p_ii_in, p_ri_in, p_ir_in;
   logic signed [MW-1:0] p_aa_in, p_ab_in, p_bb_in, p_bc_in;
   logic signed [W:0]    add_re_in, add_im_in, sub_re_in, sub_im_in;
   logic signed [MW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [MW-1:0] p_aa_ff, p_ab_ff, p_bb_ff, p_bc_ff;
   logic signed [W:0]    add_re_ff, add_im_ff, sub_re_ff, sub_im_ff;
   logic                 s2_valid_ff;
   logic [2:0]           s2_op_ff;

   assign p_rr_in = $signed(s1_ff.a_re) * $signed(s1_ff.b_re);
   assign p_ii_in = $signed(s1_ff.a_im) * $signed(s1_ff.b_im);
   assign p_ri_in = $signed(s1_ff.a_re) * $signed(s1_ff.b_im);
   assign p_ir_in = $signed(s1_ff.a_im) * $signed(s1_ff.b_re);
   assign p_aa_in = $signed(s1_ff.a_re) * $signed(s1_ff.a_re);
   assign p_ab_in = $signed(s1_ff.a_im) * $signed(s1_ff.a_im);
   assign p_bb_in = $signed(s1_ff.b_re) * $signed(s1_ff.b_re);
   assign p_bc_in = $signed(s1_ff.b_im) * $signed(s1_ff.b_im);

   assign add_re_in = $signed({s1_ff.a_re[W-1], s1_ff.a_re}) + $signed({s1_ff.b_re[W-1], s1_ff.b_re});
   assign add_im_in = $signed({s1_ff.a_im[W-1], s1_ff.a_im}) + $signed({s1_ff.b_im[W-1], s1_ff.b_im});
   assign sub_re_in = $signed({s1_ff.a_re[W-1], s1_ff.a_re}) - $signed({s1_ff.b_re[W-1], s1_ff.b_re});
   assign sub_im_in = $signed({s1_ff.a_im[W-1], s1_ff.a_im}) - $signed({s1_ff.b_im[W-1], s1_ff.b_im});

   always_ff @(posedge clock) begin
      p_rr_ff   <= p_rr_in;
      p_ii_ff   <= p_ii_in;
      p_ri_ff   <= p_ri_in;
      p_ir_ff   <= p_ir_in;
      p_aa_ff   <= p_aa_in;
      p_ab_ff   <= p_ab_in;
      p_bb_ff   <= p_bb_in;
      p_bc_ff   <= p_bc_in;
      add_re_ff <= add_re_in;
      add_im_ff <= add_im_in;
      sub_re_ff <= sub_re_in;
      sub_im_ff <= sub_im_in;
      s2_op_ff  <= s1_ff.opcode;
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Stage 3: combine products, set up divider and root lanes
   logic [MW:0]     mul_re, mul_im, div_re, div_im, add_re, add_im, sub_re, sub_im;
   logic [MW-1:0]   div_re_mag, div_im_mag, den, sq_s;
   logic [MW+F-1:0] num_re, num_im;
   logic [MW-1:0]   hi_re, hi_im;
   cau_pkg::pipe_type pipe_in, pipe_ff;

   assign mul_re = {p_rr_ff[MW-1], p_rr_ff} - {p_ii_ff[MW-1], p_ii_ff};
   assign mul_im = {p_ri_ff[MW-1], p_ri_ff} + {p_ir_ff[MW-1], p_ir_ff};
   assign div_re = {p_rr_ff[MW-1], p_rr_ff} + {p_ii_ff[MW-1], p_ii_ff};
   assign div_im = {p_ir_ff[MW-1], p_ir_ff} - {p_ri_ff[MW-1], p_ri_ff};
   assign add_re = {{(MW-W){add_re_ff[W]}}, add_re_ff};
   assign add_im = {{(MW-W){add_im_ff[W]}}, add_im_ff};
   assign sub_re = {{(MW-W){sub_re_ff[W]}}, sub_re_ff};
   assign sub_im = {{(MW-W){sub_im_ff[W]}}, sub_im_ff};

   assign den        = p_bb_ff + p_bc_ff;
   assign sq_s       = p_aa_ff + p_ab_ff;
   assign div_re_mag = cau_pkg::abs_mag(div_re);
   assign div_im_mag = cau_pkg::abs_mag(div_im);
   assign num_re     = {div_re_mag, {F{1'b0}}};
   assign num_im     = {div_im_mag, {F{1'b0}}};
   assign hi_re      = {{(W-F){1'b0}}, num_re[MW+F-1:W]};
   assign hi_im      = {{(W-F){1'b0}}, num_im[MW+F-1:W]};

   always_comb begin
      pipe_in        = '0;
      pipe_in.valid  = s2_valid_ff;
      pipe_in.op     = s2_op_ff;
      pipe_in.den    = den;
      pipe_in.divz   = (den == '0);
      pipe_in.re_ovf = (hi_re >= den);
      pipe_in.im_ovf = (hi_im >= den);
      pipe_in.re_rem = hi_re;
      pipe_in.im_rem = hi_im;
      pipe_in.re_lo  = num_re[W-1:0];
      pipe_in.im_lo  = num_im[W-1:0];
      pipe_in.sq_s   = sq_s;
      case (s2_op_ff)
         cau_pkg::OP_ADD: begin
            pipe_in.re_neg = add_re[MW];
            pipe_in.re_mag = cau_pkg::abs_mag(add_re);
            pipe_in.im_neg = add_im[MW];
            pipe_in.im_mag = cau_pkg::abs_mag(add_im);
         end
         cau_pkg::OP_SUB: begin
            pipe_in.re_neg = sub_re[MW];
            pipe_in.re_mag = cau_pkg::abs_mag(sub_re);
            pipe_in.im_neg = sub_im[MW];
            pipe_in.im_mag = cau_pkg::abs_mag(sub_im);
         end
         cau_pkg::OP_MUL: begin
            // truncate magnitude: rounds toward zero
            pipe_in.re_neg = mul_re[MW];
            pipe_in.re_mag = cau_pkg::abs_mag(mul_re) >> F;
            pipe_in.im_neg = mul_im[MW];
            pipe_in.im_mag = cau_pkg::abs_mag(mul_im) >> F;
         end
         cau_pkg::OP_DIV: begin
            pipe_in.re_neg = div_re[MW];
            pipe_in.im_neg = div_im[MW];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_ff <= '0;
      end else begin
         pipe_ff <= pipe_in;
      end
   end

   assign pipe_out = pipe_ff;

endmodule

### hw/rtl/cau_step.sv
module cau_step (
   input  logic              clock,
   input  logic              reset,
   input  cau_pkg::pipe_type pipe_in,
   output cau_pkg::pipe_type pipe_out
);

   localparam int W  = cau_pkg::WORD_BITS;
   localparam int MW = cau_pkg::MAG_BITS;
   localparam int SQ = cau_pkg::SQ_BITS;

   logic [MW:0]   re_r2, im_r2, re_diff, im_diff, den_x;
   logic          re_ge, im_ge, sq_ge;
   logic [SQ+1:0] sq_sh, sq_t, sq_diff;
   cau_pkg::pipe_type step_in, step_ff;

   // One quotient bit for each divider lane
   assign den_x   = {1'b0, pipe_in.den};
   assign re_r2   = {pipe_in.re_rem, pipe_in.re_lo[W-1]};
   assign im_r2   = {pipe_in.im_rem, pipe_in.im_lo[W-1]};
   assign re_ge   = (re_r2 >= den_x);
   assign im_ge   = (im_r2 >= den_x);
   assign re_diff = re_r2 - den_x;
   assign im_diff = im_r2 - den_x;

   // One root bit: bring in two radicand bits, try (4q + 1)
   assign sq_sh   = {pipe_in.sq_rem, pipe_in.sq_s[MW-1:MW-2]};
   assign sq_t    = {2'b00, pipe_in.sq_q, 2'b01};
   assign sq_ge   = (sq_sh >= sq_t);
   assign sq_diff = sq_sh - sq_t;

   always_comb begin
      step_in        = pipe_in;
      step_in.re_rem = re_ge ? re_diff[MW-1:0] : re_r2[MW-1:0];
      step_in.im_rem = im_ge ? im_diff[MW-1:0] : im_r2[MW-1:0];
      step_in.re_q   = {pipe_in.re_q[W-2:0], re_ge};
      step_in.im_q   = {pipe_in.im_q[W-2:0], im_ge};
      step_in.re_lo  = {pipe_in.re_lo[W-2:0], 1'b0};
      step_in.im_lo  = {pipe_in.im_lo[W-2:0], 1'b0};
      step_in.sq_rem = sq_ge ? sq_diff[SQ-1:0] : sq_sh[SQ-1:0];
      step_in.sq_q   = {pipe_in.sq_q[W-2:0], sq_ge};
      step_in.sq_s   = {pipe_in.sq_s[MW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   assign pipe_out = step_ff;

endmodule

### hw/rtl/cau_back.sv
module cau_back (
   input  logic              clock,
   input  logic              reset,
   input  cau_pkg::pipe_type pipe_in,
   output logic              rsp_valid,
   output cau_pkg::rsp_type  rsp_data
);

   localparam int W  = cau_pkg::WORD_BITS;
   localparam int MW = cau_pkg::MAG_BITS;
   localparam logic [MW-1:0] POS_MAX = MW'((64'd1 << (W - 1)) - 64'd1);
   localparam logic [MW-1:0] NEG_MAX = MW'(64'd1 << (W - 1));

   logic [MW-1:0]    re_mag, im_mag;
   logic             re_neg, im_neg, re_sat, im_sat, divz;
   logic [W-1:0]     re_word, im_word;
   cau_pkg::rsp_type rsp_in, rsp_ff;
   logic             rsp_valid_ff;

   // Pick the finished magnitude for the opcode
   always_comb begin
      re_mag = '0;
      im_mag = '0;
      re_neg = 1'b0;
      im_neg = 1'b0;
      divz   = 1'b0;
      case (pipe_in.op)
         cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL: begin
            re_mag = pipe_in.re_mag;
            im_mag = pipe_in.im_mag;
            re_neg = pipe_in.re_neg;
            im_neg = pipe_in.im_neg;
         end
         cau_pkg::OP_DIV: begin
            if (pipe_in.divz) begin
               divz = 1'b1;
            end else begin
               // quotient too large for the lane: force saturation
               re_mag = pipe_in.re_ovf ? '1 : {{(MW-W){1'b0}}, pipe_in.re_q};
               im_mag = pipe_in.im_ovf ? '1 : {{(MW-W){1'b0}}, pipe_in.im_q};
               re_neg = pipe_in.re_neg;
               im_neg = pipe_in.im_neg;
            end
         end
         cau_pkg::OP_MAG: begin
            re_mag = {{(MW-W){1'b0}}, pipe_in.sq_q};
         end
         default: begin
         end
      endcase
   end

   // Saturate to the signed word range
   always_comb begin
      re_sat  = re_neg ? (re_mag > NEG_MAX) : (re_mag > POS_MAX);
      im_sat  = im_neg ? (im_mag > NEG_MAX) : (im_mag > POS_MAX);
      re_word = re_sat ? (re_neg ? NEG_MAX[W-1:0] : POS_MAX[W-1:0])
                       : (re_neg ? (~re_mag[W-1:0] + 1'b1) : re_mag[W-1:0]);
      im_word = im_sat ? (im_neg ? NEG_MAX[W-1:0] : POS_MAX[W-1:0])
                       : (im_neg ? (~im_mag[W-1:0] + 1'b1) : im_mag[W-1:0]);
      rsp_in.res_re = re_word;
      rsp_in.res_im = im_word;
      if (divz) begin
         rsp_in.status = cau_pkg::ST_DIVZ;
      end else if (re_sat || im_sat) begin
         rsp_in.status = cau_pkg::ST_SAT;
      end else begin
         rsp_in.status = cau_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pipe_in.valid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/complex_arith_unit_core.sv
// Complex arithmetic unit on signed Q8.8 operands: add, subtract, multiply,
// divide and magnitude, each result truncated toward zero and saturated.
// The unit is a fixed pipeline that takes one request per clock while busy
// is low; every request gives its result on rsp_data, marked by rsp_valid
// for one cycle. The pipeline is three front stages (capture, multipliers,
// combine), then WORD_BITS divider and square-root stages, which settle one
// quotient bit and one root bit per stage, then the output register.
// The receiver cannot stall the unit and needs none; busy is high only
// during reset.
module complex_arith_unit_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cau_pkg::req_type req_data,
   output logic             rsp_valid,
   output cau_pkg::rsp_type rsp_data
);

   localparam int W   = cau_pkg::WORD_BITS;
   localparam int LAT = W + 4;

   logic busy_ff;
   logic req_fire;
   cau_pkg::pipe_type stage_pipe [0:W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy     = busy_ff;
   assign req_fire = start && !busy_ff;

   cau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_data (req_data),
      .pipe_out (stage_pipe[0])
   );

   // Divider and root stages, one bit each
   for (genvar i = 0; i < W; i++) begin : g_step
      cau_step u_step (
         .clock    (clock),
         .reset    (reset),
         .pipe_in  (stage_pipe[i]),
         .pipe_out (stage_pipe[i+1])
      );
   end

   cau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pipe_in   (stage_pipe[W]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      req_fire |-> ##LAT rsp_valid)
      else $error("request did not produce a result on time");
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      !req_fire |-> ##LAT !rsp_valid)
      else $error("result without a request");
   a_divz_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == cau_pkg::ST_DIVZ) |->
      (rsp_data.res_re == '0 && rsp_data.res_im == '0))
      else $error("divide by zero gave nonzero result");
   a_mag_sign : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.opcode == cau_pkg::OP_MAG) |->
      ##LAT (rsp_data.res_re[W-1] == 1'b0 && rsp_data.res_im == '0))
      else $error("magnitude result malformed");
`endif

endmodule

### tb/cau_checker.sv
`timescale 1ns / 1ps

module cau_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  cau_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  cau_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);
   import cau_pkg::*;

   rsp_type expected_q[$];

   // Saturate a sign/magnitude value to a signed word, flag overflow
   function automatic logic [15:0] clamp_word(input logic neg, input logic [63:0] mag,
                                              inout logic ovf);
      logic [15:0] r;
      if (mag == 0) begin
         r = 16'd0;
      end else if (!neg) begin
         if (mag > 64'd32767) begin
            ovf = 1'b1;
            r = 16'h7fff;
         end else begin
            r = mag[15:0];
         end
      end else begin
         if (mag > 64'd32768) begin
            ovf = 1'b1;
            r = 16'h8000;
         end else begin
            r = -mag[15:0];
         end
      end
      return r;
   endfunction

   // Truncating fixed-point quotient, capped like the long division
   function automatic logic [63:0] fixed_quot(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      q = n / d;
      r = n % d;
      for (int i = 0; i < FRAC_BITS; i++) begin
         if (q > (64'd1 << 40)) return 64'd1 << 40;
         q = q << 1;
         r = r << 1;
         if (r >= d) begin
            q = q + 1;
            r = r - d;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] s);
      logic [63:0] res;
      res = 0;
      for (int b = 31; b >= 0; b--) begin
         if ((res | (64'd1 << b)) * (res | (64'd1 << b)) <= s) res = res | (64'd1 << b);
      end
      return res;
   endfunction

   function automatic rsp_type predict_result(input req_type rq);
      longint ar, ai, br, bi, sre, sim;
      logic [63:0] den, mre, mim;
      logic ovf;
      rsp_type r;
      ar = rq.a_re; ai = rq.a_im; br = rq.b_re; bi = rq.b_im;
      sre = 0; sim = 0; ovf = 0;
      r.status = ST_OK;
      case (rq.opcode)
         OP_ADD: begin sre = ar + br; sim = ai + bi; end
         OP_SUB: begin sre = ar - br; sim = ai - bi; end
         OP_MUL: begin
            sre = ar * br - ai * bi;
            sim = ar * bi + ai * br;
            // truncate magnitude toward zero
            sre = (sre < 0) ? -((-sre) >>> FRAC_BITS) : (sre >>> FRAC_BITS);
            sim = (sim < 0) ? -((-sim) >>> FRAC_BITS) : (sim >>> FRAC_BITS);
         end
         OP_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.status = ST_DIVZ;
            end else begin
               sre = ar * br + ai * bi;
               sim = ai * br - ar * bi;
               mre = fixed_quot((sre < 0) ? -sre : sre, den);
               mim = fixed_quot((sim < 0) ? -sim : sim, den);
               sre = (sre < 0) ? -longint'(mre) : longint'(mre);
               sim = (sim < 0) ? -longint'(mim) : longint'(mim);
            end
         end
         OP_MAG: sre = longint'(root_floor(ar * ar + ai * ai));
         default: ;
      endcase
      r.res_re = clamp_word(sre < 0, (sre < 0) ? -sre : sre, ovf);
      r.res_im = clamp_word(sim < 0, (sim < 0) ? -sim : sim, ovf);
      if (r.status == ST_OK && ovf) r.status = ST_SAT;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
   end

   assign pending = expected_q.size();

   // Predict on each accepted request, compare each strobed result
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && start && !busy) expected_q.push_back(predict_result(req_data));
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            report_mismatch("result with nothing pending");
         end else begin
            want = expected_q.pop_front();
            if (rsp_data.res_re !== want.res_re)
               report_mismatch($sformatf("res_re %h want %h", rsp_data.res_re, want.res_re));
            if (rsp_data.res_im !== want.res_im)
               report_mismatch($sformatf("res_im %h want %h", rsp_data.res_im, want.res_im));
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status %0d want %0d", rsp_data.status, want.status));
         end
      end
   end
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import cau_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      idle_pct;

   complex_arith_unit_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   cau_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [15:0] pick_part();
      case ($urandom_range(0, 7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'($signed($urandom_range(0, 1024)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   // Hold one request on the port until taken, idling at random first
   task automatic send_request(input req_type rq);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      req_type rq;
      rq.opcode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
      rq.a_re = pick_part();
      rq.a_im = pick_part();
      rq.b_re = pick_part();
      rq.b_im = pick_part();
      if (rq.opcode == OP_DIV && $urandom_range(0, 9) == 0) begin
         rq.b_re = 0;
         rq.b_im = 0;
      end
      send_request(rq);
   endtask

   initial begin
      int waited;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      idle_pct = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes per opcode, zero divisor, unused opcodes
      for (int op = 0; op < 8; op++) begin
         send_request('{opcode: 3'(op), a_re: 16'h7fff, a_im: 16'h8000,
                        b_re: 16'h8000, b_im: 16'h7fff});
         send_request('{opcode: 3'(op), a_re: 16'h0100, a_im: 16'hff00,
                        b_re: 16'h0200, b_im: 16'h0080});
      end
      send_request('{opcode: OP_DIV, a_re: 16'h0100, a_im: 16'h0100, b_re: 0, b_im: 0});
      send_request('{opcode: OP_DIV, a_re: 16'h7fff, a_im: 16'h7fff, b_re: 0, b_im: 16'h0001});
      send_request('{opcode: OP_MAG, a_re: 16'h8000, a_im: 16'h8000, b_re: 0, b_im: 0});
      send_request('{opcode: OP_MUL, a_re: 16'h8000, a_im: 0, b_re: 16'h8000, b_im: 0});

      // Random phases with varied sender idling
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 1) ? 58 : (phase == 2) ? 26 : 0;
         for (int i = 0; i < 475; i++) send_random();
         if (phase == 1) begin
            // sender drains the pipe before going on
            start <= 1'b0;
            while (pending != 0) @(negedge clock);
         end
      end
      start <= 1'b0;

      waited = 0;
      while (pending != 0 && waited < 1000) begin
         @(negedge clock);
         waited++;
      end
      repeat (30) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS complex_arith_unit_core");
      end else begin
         $display("FAIL complex_arith_unit_core");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL complex_arith_unit_core");
      $finish;
   end
endmodule
